@@ rtl/omc_pkg.sv @@
// Shared types, controller states, datapath commands and helpers for the merge-cost block.
package omc_pkg;

    typedef struct packed {
        logic [15:0] record_size;
        logic        last_record;
    } t_in;

    typedef struct packed {
        logic [31:0] total_cost;
        logic [8:0]  record_count;
        logic        overflowed;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_MRG_CHK,
        ST_REM_RD0,
        ST_REM_RD1,
        ST_REM_LD,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_DN_MV,
        ST_REM_DONE,
        ST_ACC,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_UP_CHK,
        OP_UP_CMP,
        OP_REM_RD0,
        OP_REM_RD1,
        OP_REM_LD,
        OP_DN_L,
        OP_DN_R,
        OP_DN_CMP,
        OP_DN_MV,
        OP_SAVE_A,
        OP_MRG_SUM,
        OP_ACC,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic up_swap;
        logic cnt_gt1;
        logic cnt_zero;
        logic lc_ok;
        logic rc_ok;
        logic best_self;
    } t_status;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT32 : s[31:0];
    endfunction

endpackage

@@ rtl/optimal_merge_cost_top.sv @@
// Top level of the optimal merge cost block: controller plus heap datapath.
//
//  channel | valid       | ready       | payload      | beat
//  --------+-------------+-------------+--------------+------------------------------
//  input   | i_in_valid  | o_in_ready  | i_in_data    | one record size, last flag
//  output  | o_out_valid | i_out_ready | o_out_data   | cost, kept count, overflow
//
// A record is accepted, then climbs the heap one level per check and compare step and is
// written where it settles. Parent reads go through the single read port of the heap RAM,
// whose read data is registered.
// After the last record each merge checks the count, then does two removals (read the
// root, read the last entry, load it and sift it down, comparing children at each level),
// adds the sum to the total and inserts the sum like a record; the result is then emitted.
// Reset is synchronous and clears the count, overflow flag, total and controller; the
// heap needs no clearing. A waiting result does not block the next record; only a
// second result waits until the first is taken.
module optimal_merge_cost_top
    import omc_pkg::*;
#(
    parameter int MAX_RECORDS = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd    w_cmd;
    t_status w_status;

    omc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in_data.last_record),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    omc_dpath #(
        .MAX_RECORDS(MAX_RECORDS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_out_data(o_out_data)
    );

endmodule

@@ rtl/omc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module omc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/omc_ctrl.sv @@
// Sequencer for record insertion, heap merges and result hand-off.
module omc_ctrl
    import omc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_second, n_second;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last      <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_second    = r_second;
        n_out_valid = r_out_valid;
        o_cmd.op    = OP_NONE;
        o_in_ready  = 1'b0;

        // drop the result beat once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_last   = i_last;
                    if (!i_status.full) begin
                        n_state = ST_UP_CHK;
                    end else if (i_last) begin
                        n_state = ST_MRG_CHK;
                    end
                end
            end
            ST_UP_CHK: begin
                o_cmd.op = OP_UP_CHK;
                if (!i_status.idx_zero) begin
                    n_state = ST_UP_CMP;
                end else begin
                    n_state = r_last ? ST_MRG_CHK : ST_IDLE;
                end
            end
            ST_UP_CMP: begin
                o_cmd.op = OP_UP_CMP;
                if (i_status.up_swap) begin
                    n_state = ST_UP_CHK;
                end else begin
                    n_state = r_last ? ST_MRG_CHK : ST_IDLE;
                end
            end
            ST_MRG_CHK: begin
                n_second = 1'b0;
                n_state  = i_status.cnt_gt1 ? ST_REM_RD0 : ST_EMIT;
            end
            ST_REM_RD0: begin
                o_cmd.op = OP_REM_RD0;
                n_state  = ST_REM_RD1;
            end
            ST_REM_RD1: begin
                o_cmd.op = OP_REM_RD1;
                n_state  = i_status.cnt_zero ? ST_REM_DONE : ST_REM_LD;
            end
            ST_REM_LD: begin
                o_cmd.op = OP_REM_LD;
                n_state  = ST_DN_L;
            end
            ST_DN_L: begin
                o_cmd.op = OP_DN_L;
                n_state  = i_status.lc_ok ? ST_DN_R : ST_REM_DONE;
            end
            ST_DN_R: begin
                o_cmd.op = OP_DN_R;
                n_state  = i_status.rc_ok ? ST_DN_CMP : ST_DN_MV;
            end
            ST_DN_CMP: begin
                o_cmd.op = OP_DN_CMP;
                n_state  = ST_DN_MV;
            end
            ST_DN_MV: begin
                o_cmd.op = OP_DN_MV;
                n_state  = i_status.best_self ? ST_REM_DONE : ST_DN_L;
            end
            ST_REM_DONE: begin
                if (!r_second) begin
                    o_cmd.op = OP_SAVE_A;
                    n_second = 1'b1;
                    n_state  = ST_REM_RD0;
                end else begin
                    o_cmd.op = OP_MRG_SUM;
                    n_state  = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_UP_CHK;
            end
            ST_EMIT: begin
                // wait for a free result slot
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/omc_dpath.sv @@
// Heap datapath: heap RAM, count, sift registers, running total and result register.
module omc_dpath
    import omc_pkg::*;
#(
    parameter int MAX_RECORDS = 256
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_in_data,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output t_out    o_out_data
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int XW = AW + 2;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_kept, n_kept;
    logic          r_drop, n_drop;
    logic [31:0]   r_total, n_total;
    logic [AW-1:0] r_idx, n_idx;
    logic [31:0]   r_val, n_val;
    logic [31:0]   r_top, n_top;
    logic [31:0]   r_a, n_a;
    logic [31:0]   r_best_val, n_best_val;
    logic [AW-1:0] r_best_idx, n_best_idx;
    logic          r_best_self, n_best_self;
    t_out          r_out, n_out;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rdata;

    logic [AW-1:0] w_parent;
    logic [XW-1:0] w_lc;
    logic [XW-1:0] w_rc;
    logic [XW-1:0] w_cnt_x;
    logic          w_full;
    logic [CW+8:0] w_kept_ext;

    omc_ram #(
        .WIDTH(32),
        .DEPTH(MAX_RECORDS)
    ) u_heap (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_parent   = (r_idx - AW'(1)) >> 1;
    assign w_lc       = XW'({r_idx, 1'b1});
    assign w_rc       = w_lc + XW'(1);
    assign w_cnt_x    = XW'(r_cnt);
    assign w_full     = (r_cnt == CW'(MAX_RECORDS));
    assign w_kept_ext = {9'd0, r_kept};

    assign o_status.full      = w_full;
    assign o_status.idx_zero  = (r_idx == '0);
    assign o_status.up_swap   = (w_rdata > r_val);
    assign o_status.cnt_gt1   = (r_cnt > CW'(1));
    assign o_status.cnt_zero  = (r_cnt == '0);
    assign o_status.lc_ok     = (w_lc < w_cnt_x);
    assign o_status.rc_ok     = (w_rc < w_cnt_x);
    assign o_status.best_self = r_best_self;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_total <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kept      <= n_kept;
        r_idx       <= n_idx;
        r_val       <= n_val;
        r_top       <= n_top;
        r_a         <= n_a;
        r_best_val  <= n_best_val;
        r_best_idx  <= n_best_idx;
        r_best_self <= n_best_self;
        r_out       <= n_out;
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_kept      = r_kept;
        n_drop      = r_drop;
        n_total     = r_total;
        n_idx       = r_idx;
        n_val       = r_val;
        n_top       = r_top;
        n_a         = r_a;
        n_best_val  = r_best_val;
        n_best_idx  = r_best_idx;
        n_best_self = r_best_self;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = r_val;
        w_raddr     = '0;

        case (i_cmd.op)
            OP_ACCEPT: begin
                if (w_full) begin
                    n_drop = 1'b1;
                    n_kept = r_cnt;
                end else begin
                    n_val  = {16'd0, i_in_data.record_size};
                    n_idx  = r_cnt[AW-1:0];
                    n_cnt  = r_cnt + CW'(1);
                    n_kept = r_cnt + CW'(1);
                end
            end
            OP_UP_CHK: begin
                if (r_idx == '0) begin
                    w_we = 1'b1;
                end else begin
                    w_raddr = w_parent;
                end
            end
            OP_UP_CMP: begin
                w_we = 1'b1;
                // move the parent down into the hole
                if (w_rdata > r_val) begin
                    w_wdata = w_rdata;
                    n_idx   = w_parent;
                end
            end
            OP_REM_RD0: begin
                w_raddr = '0;
                n_cnt   = r_cnt - CW'(1);
            end
            OP_REM_RD1: begin
                n_top   = w_rdata;
                w_raddr = r_cnt[AW-1:0];
            end
            OP_REM_LD: begin
                n_val = w_rdata;
                n_idx = '0;
            end
            OP_DN_L: begin
                if (w_lc < w_cnt_x) begin
                    w_raddr = w_lc[AW-1:0];
                end else begin
                    w_we = 1'b1;
                end
            end
            OP_DN_R: begin
                if (w_rdata < r_val) begin
                    n_best_val  = w_rdata;
                    n_best_idx  = w_lc[AW-1:0];
                    n_best_self = 1'b0;
                end else begin
                    n_best_val  = r_val;
                    n_best_self = 1'b1;
                end
                if (w_rc < w_cnt_x) begin
                    w_raddr = w_rc[AW-1:0];
                end
            end
            OP_DN_CMP: begin
                if (w_rdata < r_best_val) begin
                    n_best_val  = w_rdata;
                    n_best_idx  = w_rc[AW-1:0];
                    n_best_self = 1'b0;
                end
            end
            OP_DN_MV: begin
                w_we = 1'b1;
                // pull the smaller child up and follow it
                if (!r_best_self) begin
                    w_wdata = r_best_val;
                    n_idx   = r_best_idx;
                end
            end
            OP_SAVE_A: begin
                n_a = r_top;
            end
            OP_MRG_SUM: begin
                n_val = add_sat(r_a, r_top);
                n_idx = r_cnt[AW-1:0];
                n_cnt = r_cnt + CW'(1);
            end
            OP_ACC: begin
                n_total = add_sat(r_total, r_val);
            end
            OP_EMIT: begin
                n_out.total_cost   = r_total;
                n_out.record_count = w_kept_ext[8:0];
                n_out.overflowed   = r_drop;
                n_cnt              = '0;
                n_drop             = 1'b0;
                n_total            = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_out_data = r_out;

endmodule
